@@ rtl/pos_list_pkg.sv @@
package pos_list_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int PW       = 7;
    localparam int XW       = (CW > PW) ? CW : PW;

    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_INS_TAIL = 3'd1;
    localparam logic [2:0] OP_INS_POS  = 3'd2;
    localparam logic [2:0] OP_REM_HEAD = 3'd3;
    localparam logic [2:0] OP_REM_TAIL = 3'd4;
    localparam logic [2:0] OP_REM_POS  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic signed [31:0] ERR_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [PW-1:0]      position;
    } t_req;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [PW-1:0]      entry_count;
    } t_rsp;

endpackage

@@ rtl/positional_list_engine_top.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in a memory with one write
// port and a registered read. Each request inserts at head, tail or a position, or removes
// from head, tail or a position, and gives one response with the removed value, a
// status and the new entry count. An insert at position p on a list of n entries
// moves n-p entries and a remove at p reads n-p entries (the first one read is the
// value taken out), one per cycle through the memory's read-modify-write path. A
// request goes from idle to the shift state, where it reads and moves its entries and an
// insert writes its value, and then to the final state, where its response is staged;
// an error or unused op goes straight from idle to the final state. One request is
// worked on at a time; the next is taken while the previous response still waits in
// the output register, and the final state holds while that register stays full and
// its response is not taken.
module positional_list_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  pos_list_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output pos_list_pkg::t_rsp o_rsp
);
    import pos_list_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rd_left;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_pos;
    logic               r_pend;
    logic               r_cap;
    logic               r_is_ins;
    logic               r_up;
    logic signed [31:0] r_value;
    logic signed [31:0] r_res;
    logic [1:0]         r_st;
    logic               r_out_valid;
    t_rsp               r_out;

    // decode of the incoming request
    logic          acc;
    logic [1:0]    n_st;
    logic          n_ins;
    logic          n_rem;
    logic [CW-1:0] n_pos;
    logic          full;
    logic          empty;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;

    // memory port controls
    logic          rd_en;
    logic          shift_wr;
    logic          final_wr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [31:0] wr_data;

    assign o_req_ready = (r_state == S_IDLE);
    assign acc         = i_req_valid && o_req_ready;
    assign full        = (r_count == CW'(CAPACITY));
    assign empty       = (r_count == '0);
    assign pos_x       = XW'(i_req.position);
    assign cnt_x       = XW'(r_count);

    always_comb begin
        n_st  = ST_OK;
        n_ins = 1'b0;
        n_rem = 1'b0;
        n_pos = '0;
        unique case (i_req.op)
            OP_INS_HEAD: begin
                if (full) n_st = ST_FULL;
                else n_ins = 1'b1;
                n_pos = '0;
            end
            OP_INS_TAIL: begin
                if (full) n_st = ST_FULL;
                else n_ins = 1'b1;
                n_pos = r_count;
            end
            OP_INS_POS: begin
                if (full) n_st = ST_FULL;
                else if (pos_x > cnt_x) n_st = ST_BADPOS;
                else n_ins = 1'b1;
                n_pos = CW'(i_req.position);
            end
            OP_REM_HEAD: begin
                if (empty) n_st = ST_EMPTY;
                else n_rem = 1'b1;
                n_pos = '0;
            end
            OP_REM_TAIL: begin
                if (empty) n_st = ST_EMPTY;
                else n_rem = 1'b1;
                n_pos = r_count - CW'(1);
            end
            OP_REM_POS: begin
                if (empty) n_st = ST_EMPTY;
                else if (pos_x >= cnt_x) n_st = ST_BADPOS;
                else n_rem = 1'b1;
                n_pos = CW'(i_req.position);
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
    end

    assign rd_en    = (r_state == S_SHIFT) && (r_rd_left != '0);
    assign shift_wr = (r_state == S_SHIFT) && r_pend && !r_cap;
    assign final_wr = (r_state == S_SHIFT) && (r_rd_left == '0) && !r_pend && r_is_ins;
    assign wr_en    = shift_wr || final_wr;
    assign wr_addr  = final_wr ? r_pos : r_wr_ptr;
    assign wr_data  = final_wr ? r_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_left   <= '0;
            r_pend      <= 1'b0;
            r_cap       <= 1'b0;
            r_is_ins    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_rsp_ready && (r_state != S_FIN)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_value  <= i_req.value;
                        r_st     <= n_st;
                        r_is_ins <= n_ins;
                        r_up     <= n_rem;
                        r_cap    <= n_rem;
                        r_pend   <= 1'b0;
                        r_pos    <= AW'(n_pos);
                        r_res    <= (n_st != ST_OK) ? ERR_VALUE : 32'sd0;
                        if (n_ins) begin
                            r_rd_left <= r_count - n_pos;
                            r_rd_ptr  <= AW'(r_count - CW'(1));
                            r_wr_ptr  <= AW'(r_count);
                            r_count   <= r_count + CW'(1);
                            r_state   <= S_SHIFT;
                        end else if (n_rem) begin
                            r_rd_left <= r_count - n_pos;
                            r_rd_ptr  <= AW'(n_pos);
                            r_wr_ptr  <= AW'(n_pos);
                            r_count   <= r_count - CW'(1);
                            r_state   <= S_SHIFT;
                        end else begin
                            r_rd_left <= '0;
                            r_state   <= S_FIN;
                        end
                    end
                end
                S_SHIFT: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_rd_left <= r_rd_left - CW'(1);
                        r_rd_ptr  <= r_up ? r_rd_ptr + AW'(1) : r_rd_ptr - AW'(1);
                    end
                    if (shift_wr) begin
                        r_wr_ptr <= r_up ? r_wr_ptr + AW'(1) : r_wr_ptr - AW'(1);
                    end
                    // first word read by a removal is the value taken out
                    if (r_pend && r_cap) begin
                        r_res <= r_rd_data;
                        r_cap <= 1'b0;
                    end
                    if ((r_rd_left == '0) && !r_pend) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_rsp_ready) begin
                        r_out.removed_value <= r_res;
                        r_out.status        <= r_st;
                        r_out.entry_count   <= PW'(r_count);
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (r_rd_ptr != wr_addr))
        else $error("read and write hit the same entry");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_rem) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ((r_rd_left == '0) && !r_pend && !r_cap))
        else $error("response staged with shift still in flight");
`endif

endmodule
